>>> rtl/tournament_branch_predictor_assert.svh
// assertion macros used by the predictor rtl
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication
`define TBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbp check failed");

// next-cycle implication
`define TBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbp check failed");

`endif

>>> rtl/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

  localparam int unsigned GLOBAL_INDEX_BITS_DEF  = 16;
  localparam int unsigned CHOOSER_INDEX_BITS_DEF = 15;
  localparam int unsigned LOCAL_TABLE_BITS_DEF   = 10;
  localparam int unsigned LOCAL_HISTORY_BITS_DEF = 16;

  localparam int unsigned PC_BITS = 32;
  localparam int unsigned CTR_W   = 2;

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_MAX  = 2'd3;
  localparam ctr_t CTR_MIN  = 2'd0;
  localparam ctr_t CTR_INIT = 2'd2;

  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  function automatic ctr_t sat_move(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tbp_table.sv
`default_nettype none

module tbp_table #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 2
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [(2**AW)-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tournament_branch_predictor.sv
`default_nettype none
`include "tournament_branch_predictor_assert.svh"

// Tournament branch predictor (gshare plus local two-level, 2-bit chooser). Each
// transaction is a predict or an update request and returns one result. Items are
// handled one at a time; each passes from acceptance through the table read,
// dependent counter read and write back states to the result register, and a new item
// is accepted only back in the idle state, while the previous result may still wait on
// out_tready. The rate is set by the dependent read chain: the local history must be
// read before its counter can be addressed. After reset a clearing pass over
// 2**max(index widths) addresses (65536 with default parameters) loads the counter and
// history tables; in_tready stays low during that pass.
module tournament_branch_predictor #(
  parameter int unsigned GLOBAL_INDEX_BITS  = tbp_pkg::GLOBAL_INDEX_BITS_DEF,
  parameter int unsigned CHOOSER_INDEX_BITS = tbp_pkg::CHOOSER_INDEX_BITS_DEF,
  parameter int unsigned LOCAL_TABLE_BITS   = tbp_pkg::LOCAL_TABLE_BITS_DEF,
  parameter int unsigned LOCAL_HISTORY_BITS = tbp_pkg::LOCAL_HISTORY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // pc[31:0], taken, pred_dir, zero pad
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // predict_taken, used_local, zero pad
);
  import tbp_pkg::*;

  localparam int unsigned GW = GLOBAL_INDEX_BITS;
  localparam int unsigned CW = CHOOSER_INDEX_BITS;
  localparam int unsigned TW = LOCAL_TABLE_BITS;
  localparam int unsigned HW = LOCAL_HISTORY_BITS;
  localparam int unsigned M1 = (GW > CW) ? GW : CW;
  localparam int unsigned M2 = (TW > HW) ? TW : HW;
  localparam int unsigned CLR_W = (M1 > M2) ? M1 : M2;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_IDX  = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [GW-1:0]     ghist_r, ghist_nxt;
  logic              fwd_r, fwd_nxt;
  ctr_t              fwd_val_r, fwd_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_pred_r, out_pred_nxt;
  logic              out_local_r, out_local_nxt;

  logic [PC_BITS-1:0] pc_r;
  logic               type_r;
  logic               taken_r;
  logic               pd_r;

  logic              clearing;
  logic              accept;
  logic              adv;
  logic              is_upd;

  logic [GW-1:0]     gi_old, gi_new;
  logic [CW-1:0]     ci;
  logic [TW-1:0]     ti;
  logic [HW-1:0]     li;

  logic              g_rd_en, g_wr_en;
  logic [GW-1:0]     g_rd_addr, g_wr_addr;
  ctr_t              g_rd_data, g_wr_data;

  logic              c_rd_en, c_wr_en;
  logic [CW-1:0]     c_wr_addr;
  ctr_t              c_rd_data, c_wr_data;

  logic              h_rd_en, h_wr_en;
  logic [TW-1:0]     h_wr_addr;
  logic [HW-1:0]     h_rd_data, h_wr_data;

  logic              l_rd_en, l_wr_en;
  logic [HW-1:0]     l_wr_addr;
  ctr_t              l_rd_data, l_wr_data;

  ctr_t              g_upd;
  logic              g_dir, l_dir, use_local;
  logic              ch_up, ch_dn;

  assign clearing = (state_r == ST_CLR);
  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign adv = (state_r == ST_WB) && (!out_valid_r || out_tready);
  assign is_upd = (type_r == REQ_UPDATE);

  assign gi_old = pc_r[GW-1:0] ^ ghist_r;
  assign gi_new = pc_r[GW-1:0] ^ {ghist_r[GW-2:0], taken_r};
  assign ci = pc_r[PC_BITS-1 -: CW];
  assign ti = pc_r[PC_BITS-1 -: TW];
  assign li = pc_r[HW-1:0] ^ h_rd_data;

  assign g_upd = sat_move(g_rd_data, taken_r);
  assign g_dir = fwd_r ? fwd_val_r[1] : g_rd_data[1];
  assign l_dir = l_rd_data[1];
  assign use_local = c_rd_data[1];
  assign ch_up = (g_dir != pd_r) && (l_dir == pd_r);
  assign ch_dn = (g_dir == pd_r) && (l_dir != pd_r);

  // table port control
  always_comb begin
    g_rd_en   = (state_r == ST_RD) || (state_r == ST_IDX);
    g_rd_addr = ((state_r == ST_IDX) && is_upd) ? gi_new : gi_old;
    g_wr_en   = clearing || ((state_r == ST_IDX) && is_upd);
    g_wr_addr = clearing ? clr_cnt_r[GW-1:0] : gi_old;
    g_wr_data = clearing ? CTR_INIT : g_upd;

    c_rd_en   = (state_r == ST_RD);
    c_wr_en   = clearing || (adv && is_upd && (ch_up || ch_dn));
    c_wr_addr = clearing ? clr_cnt_r[CW-1:0] : ci;
    c_wr_data = clearing ? CTR_MIN : sat_move(c_rd_data, ch_up);

    h_rd_en   = (state_r == ST_RD);
    h_wr_en   = clearing || (adv && is_upd);
    h_wr_addr = clearing ? clr_cnt_r[TW-1:0] : ti;
    h_wr_data = clearing ? '0 : {h_rd_data[HW-2:0], taken_r};

    l_rd_en   = (state_r == ST_IDX);
    l_wr_en   = clearing || (adv && is_upd);
    l_wr_addr = clearing ? clr_cnt_r[HW-1:0] : li;
    l_wr_data = clearing ? CTR_INIT : sat_move(l_rd_data, taken_r);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ghist_nxt     = ghist_r;
    fwd_nxt       = fwd_r;
    fwd_val_nxt   = fwd_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pred_nxt  = out_pred_r;
    out_local_nxt = out_local_r;
    unique case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        // new gshare index may hit the entry written this cycle
        fwd_nxt     = is_upd && (gi_new == gi_old);
        fwd_val_nxt = g_upd;
        if (is_upd) begin
          ghist_nxt = {ghist_r[GW-2:0], taken_r};
        end
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_pred_nxt  = is_upd ? 1'b0 : (use_local ? l_dir : g_dir);
          out_local_nxt = use_local;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      ghist_r     <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ghist_r     <= ghist_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_val_r   <= fwd_val_nxt;
    out_pred_r  <= out_pred_nxt;
    out_local_r <= out_local_nxt;
    if (accept) begin
      pc_r    <= in_tdata[PC_BITS-1:0];
      taken_r <= in_tdata[32];
      pd_r    <= in_tdata[33];
      type_r  <= in_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_local_r, out_pred_r};

  tbp_table #(.AW(GW), .DW(CTR_W)) u_global (
    .clk     (clk),
    .rd_en   (g_rd_en),
    .rd_addr (g_rd_addr),
    .rd_data (g_rd_data),
    .wr_en   (g_wr_en),
    .wr_addr (g_wr_addr),
    .wr_data (g_wr_data)
  );

  tbp_table #(.AW(CW), .DW(CTR_W)) u_chooser (
    .clk     (clk),
    .rd_en   (c_rd_en),
    .rd_addr (ci),
    .rd_data (c_rd_data),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data)
  );

  tbp_table #(.AW(TW), .DW(HW)) u_lhist (
    .clk     (clk),
    .rd_en   (h_rd_en),
    .rd_addr (ti),
    .rd_data (h_rd_data),
    .wr_en   (h_wr_en),
    .wr_addr (h_wr_addr),
    .wr_data (h_wr_data)
  );

  tbp_table #(.AW(HW), .DW(CTR_W)) u_local (
    .clk     (clk),
    .rd_en   (l_rd_en),
    .rd_addr (li),
    .rd_data (l_rd_data),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data)
  );

  `TBP_ASSERT_IMP(a_no_accept_while_clearing, clearing, !in_tready)
  `TBP_ASSERT_NXT(a_accept_starts_read, accept, state_r == ST_RD)
  `TBP_ASSERT_NXT(a_fwd_on_same_entry, (state_r == ST_IDX) && is_upd && (gi_new == gi_old), fwd_r)
  `TBP_ASSERT_NXT(a_result_after_wb, adv, out_valid_r && (state_r == ST_IDLE))
  `TBP_ASSERT_NXT(a_update_predicts_zero, adv && is_upd, !out_pred_r)

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tbp_pkg::*;

  localparam int unsigned GW = GLOBAL_INDEX_BITS_DEF;
  localparam int unsigned CW = CHOOSER_INDEX_BITS_DEF;
  localparam int unsigned TW = LOCAL_TABLE_BITS_DEF;
  localparam int unsigned HW = LOCAL_HISTORY_BITS_DEF;
  localparam int LATENCY = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic local_sel;
    logic dir;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // pc[31:0], taken, pred_dir, zero pad
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // predict_taken, used_local, zero pad

  tournament_branch_predictor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predictor state
  ctr_t          gsh_ctr   [0:(1 << GW) - 1];
  logic [GW-1:0] ghist;
  ctr_t          sel_ctr   [0:(1 << CW) - 1];
  logic [HW-1:0] lhist_tbl [0:(1 << TW) - 1];
  ctr_t          lcl_ctr   [0:(1 << HW) - 1];

  verdict_t pending_verdicts[$];
  logic     last_dir;
  int       errors;
  int       cycles = 0;
  int       n_predict;
  int       n_update;
  int       n_checked;
  int       n_local;
  int       burst_left;
  bit       gaps_on;
  bit       hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_verdicts.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic ctr_t ctr_toward(input ctr_t c, input logic up);
    if (up) return (c == CTR_MAX) ? c : ctr_t'(c + 1);
    return (c == CTR_MIN) ? c : ctr_t'(c - 1);
  endfunction

  function automatic void clear_predictor();
    for (int i = 0; i < (1 << GW); i++) gsh_ctr[i] = CTR_INIT;
    for (int i = 0; i < (1 << CW); i++) sel_ctr[i] = CTR_MIN;
    for (int i = 0; i < (1 << TW); i++) lhist_tbl[i] = '0;
    for (int i = 0; i < (1 << HW); i++) lcl_ctr[i] = CTR_INIT;
    ghist = '0;
  endfunction

  function automatic verdict_t advance_predictor(input logic req, input logic [31:0] pc,
                                                 input logic tk, input logic pd);
    verdict_t      v;
    logic [CW-1:0] sidx;
    logic [TW-1:0] tidx;
    logic [GW-1:0] gidx;
    logic [HW-1:0] lidx;
    logic          g;
    logic          l;
    sidx = pc[PC_BITS-1 -: CW];
    tidx = pc[PC_BITS-1 -: TW];
    gidx = pc[GW-1:0] ^ ghist;
    lidx = pc[HW-1:0] ^ lhist_tbl[tidx];
    v.local_sel = sel_ctr[sidx][1];
    v.dir = 1'b0;
    if (req == REQ_PREDICT) begin
      v.dir = v.local_sel ? lcl_ctr[lidx][1] : gsh_ctr[gidx][1];
    end else begin
      gsh_ctr[gidx] = ctr_toward(gsh_ctr[gidx], tk);
      ghist = {ghist[GW-2:0], tk};
      // global side is re-read at the shifted history
      g = gsh_ctr[pc[GW-1:0] ^ ghist][1];
      l = lcl_ctr[lidx][1];
      if (g != pd && l == pd) begin
        sel_ctr[sidx] = ctr_toward(sel_ctr[sidx], 1'b1);
      end else if (g == pd && l != pd) begin
        sel_ctr[sidx] = ctr_toward(sel_ctr[sidx], 1'b0);
      end
      lcl_ctr[lidx] = ctr_toward(lcl_ctr[lidx], tk);
      lhist_tbl[tidx] = {lhist_tbl[tidx][HW-2:0], tk};
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic [7:0] got);
    if (errors < 30) begin
      $display("mismatch at cycle %0d: %s, expected %0b, out_tdata %02h", cycles, what,
               want, got);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 1'b0, out_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.dir) report_mismatch("predict_taken", want.dir, out_tdata);
        if (out_tdata[1] !== want.local_sel) begin
          report_mismatch("used_local", want.local_sel, out_tdata);
        end
        n_checked++;
        if (want.local_sel) n_local++;
      end
    end
  end

  // output side stalls on randomly chosen patterns
  initial begin : rx_pacer
    int mode;
    int phase;
    int period;
    int k;
    mode = 0;
    phase = 0;
    period = 1;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase % 64 == 0) begin
          mode = $urandom_range(0, 3);
          period = $urandom_range(1, 5);
        end
        phase++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= ($urandom_range(0, 9) < 3);
          default: out_tready <= ((phase / period) % 2 == 0);
        endcase
      end
    end
  end

  task automatic idle_input(input int n);
    in_tvalid <= 1'b0;
    in_tdata  <= 40'({$urandom, $urandom});
    in_tuser  <= 1'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input logic req, input logic [31:0] pc, input logic tk,
                           input logic pd);
    verdict_t v;
    int       pause;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {6'b0, pd, tk, pc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = advance_predictor(req, pc, tk, pd);
    pending_verdicts.push_back(v);
    last_dir = v.dir;
    if (req == REQ_PREDICT) n_predict++;
    else n_update++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      pause = gaps_on ? $urandom_range(0, 6) : 0;
      if (pause > 0) idle_input(pause);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    logic [31:0] hot;
    hot = 32'hA5C3_0F96;
    gaps_on = 1'b1;
    // taken and pred_dir must not matter on a predict
    send_item(REQ_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
    send_item(REQ_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // saturate up, then down; more than a history width of shifts
    for (int i = 0; i < 20; i++) send_item(REQ_UPDATE, hot, 1'b1, i[0]);
    send_item(REQ_PREDICT, hot, 1'b0, 1'b0);
    for (int i = 0; i < 20; i++) send_item(REQ_UPDATE, hot, 1'b0, ~i[0]);
    send_item(REQ_PREDICT, hot, 1'b1, 1'b1);
    send_item(REQ_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_branch_streams(input int n_items);
    logic [31:0] pool_pc [0:15];
    int          trips   [0:15];
    logic [31:0] base;
    logic [31:0] pc;
    logic        tk;
    int          b;
    int          r;
    int          sent;
    base = $urandom;
    for (int i = 0; i < 16; i++) begin
      pool_pc[i] = $urandom;
      // half the branches share a local history entry
      if (i < 8) pool_pc[i][31:22] = base[31:22];
      if (i % 4 == 1) pool_pc[i][31:17] = pool_pc[i - 1][31:17];
      trips[i] = 0;
    end
    sent = 0;
    while (sent < n_items) begin
      if (sent % 100 == 0) gaps_on = $urandom_range(0, 2) != 0;
      r = $urandom_range(0, 99);
      b = $urandom_range(0, 15);
      pc = pool_pc[b];
      if (r < 75) begin
        case (b % 4)
          0: tk = 1'b1;
          1: tk = 1'b0;
          2: tk = (trips[b] % 5) != 4;
          default: tk = 1'($urandom);
        endcase
        trips[b]++;
        send_item(REQ_PREDICT, pc, 1'($urandom), 1'($urandom));
        send_item(REQ_UPDATE, pc, tk, last_dir);
        sent += 2;
      end else if (r < 85) begin
        send_item(REQ_UPDATE, pc, 1'($urandom), 1'($urandom));
        sent++;
      end else if (r < 92) begin
        send_item(REQ_PREDICT, pc, 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_item(1'($urandom), $urandom, 1'($urandom), 1'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_output_holdoff();
    logic [31:0] pc;
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      pc = $urandom;
      send_item(REQ_PREDICT, pc, 1'($urandom), 1'($urandom));
      send_item(REQ_UPDATE, pc, 1'($urandom), last_dir);
    end
    drain();
  endtask

  task automatic test_paused_sender();
    logic [31:0] pc;
    gaps_on = 1'b1;
    for (int i = 0; i < 6; i++) begin
      pc = $urandom;
      pc[31:24] = 8'h3C;
      for (int j = 0; j < 5; j++) begin
        send_item(REQ_PREDICT, pc, 1'($urandom), 1'($urandom));
        send_item(REQ_UPDATE, pc, $urandom_range(0, 3) != 0, last_dir);
      end
      // nothing offered until every result is back
      drain();
    end
  endtask

  initial begin
    errors = 0;
    n_predict = 0;
    n_update = 0;
    n_checked = 0;
    n_local = 0;
    burst_left = 1;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    last_dir = 1'b0;
    clear_predictor();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_branch_streams(440);
    test_output_holdoff();
    test_paused_sender();

    in_tvalid <= 1'b0;
    repeat (4 * LATENCY) @(posedge clk);
    $display("%0d predict and %0d update transactions sent, %0d results checked",
             n_predict, n_update, n_checked);
    $display("chooser picked the local side %0d times; runs with output hold-off and drains",
             n_local);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
